// ===== src/lrb_pkg.sv =====
// Package: request, result, configuration and state types for the reconnect backoff core.
`default_nettype none
package lrb_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_INIT_DELAY = 2'd0;
  localparam cfg_idx_t REG_MAX_DELAY  = 2'd1;
  localparam cfg_idx_t REG_FAST_BLINK = 2'd2;
  localparam cfg_idx_t REG_SLOW_BLINK = 2'd3;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;

  localparam logic [31:0] INIT_DELAY_RST = 32'd1000;
  localparam logic [31:0] MAX_DELAY_RST  = 32'd60000;
  localparam logic [15:0] FAST_BLINK_RST = 16'd200;
  localparam logic [15:0] SLOW_BLINK_RST = 16'd1000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        link_up;
  } in_t;

  typedef struct packed {
    logic        reconnect_now;
    logic        led_on;
    logic [1:0]  link_event;
    logic [31:0] retry_delay_ms;
  } out_t;

  typedef struct packed {
    logic [31:0] initial_delay_ms;
    logic [31:0] max_delay_ms;
    logic [15:0] fast_blink_ms;
    logic [15:0] slow_blink_ms;
  } cfg_t;

  typedef struct packed {
    logic        was_linked;
    logic [31:0] backoff_delay;
    logic [31:0] retry_deadline;
    logic [31:0] fast_mark;
    logic        fast_phase;
    logic [31:0] slow_mark;
    logic        slow_phase;
    logic        led_level;
  } state_t;

endpackage
`default_nettype wire

// ===== src/lrb_step.sv =====
// Next-state and result logic for one maintenance request.
`default_nettype none
module lrb_step import lrb_pkg::*; (
  input  wire state_t st,
  input  wire in_t    req,
  input  wire cfg_t   cfg,
  output state_t      st_nxt,
  output out_t        res
);

  logic [31:0] fast_elapsed;
  logic [31:0] slow_elapsed;
  logic        fast_hit;
  logic        slow_hit;
  logic        deadline_hit;
  logic [31:0] doubled;

  assign fast_elapsed = req.now_ms - st.fast_mark;
  assign slow_elapsed = req.now_ms - st.slow_mark;
  assign fast_hit     = fast_elapsed >= {16'd0, cfg.fast_blink_ms};
  assign slow_hit     = slow_elapsed >= {16'd0, cfg.slow_blink_ms};
  assign deadline_hit = req.now_ms >= st.retry_deadline;
  // saturating doubling
  assign doubled      = st.backoff_delay[31] ? 32'hFFFF_FFFF : {st.backoff_delay[30:0], 1'b0};

  always_comb begin
    st_nxt = st;
    res    = '0;
    res.link_event = EV_NONE;
    if (req.link_up) begin
      if (!st.was_linked) begin
        st_nxt.was_linked    = 1'b1;
        st_nxt.backoff_delay = cfg.initial_delay_ms;
        res.link_event       = EV_UP;
      end
      if (slow_hit) begin
        st_nxt.slow_mark  = req.now_ms;
        st_nxt.slow_phase = !st.slow_phase;
        st_nxt.led_level  = !st.slow_phase;
      end
    end else begin
      if (st.was_linked) begin
        st_nxt.was_linked = 1'b0;
        st_nxt.led_level  = 1'b0;
        res.link_event    = EV_DOWN;
      end
      if (fast_hit) begin
        st_nxt.fast_mark  = req.now_ms;
        st_nxt.fast_phase = !st.fast_phase;
        st_nxt.led_level  = !st.fast_phase;
      end
      if (deadline_hit) begin
        res.reconnect_now     = 1'b1;
        res.retry_delay_ms    = st.backoff_delay;
        st_nxt.retry_deadline = req.now_ms + st.backoff_delay;
        st_nxt.backoff_delay  = (doubled < cfg.max_delay_ms) ? doubled : cfg.max_delay_ms;
      end
    end
    res.led_on = st_nxt.led_level;
  end

endmodule
`default_nettype wire

// ===== src/link_reconnect_backoff_core.sv =====
// Top level: exponential backoff reconnect timer with status LED blinker.
// out_valid rises once the request has passed the input register, then the result register.
// One request per cycle while out_ready is high; the state update is one short pass in lrb_step.
// Reset (rst_n low, synchronous): pipeline empty, registers back to defaults,
// backoff delay = 1000 ms, deadline, blink marks, phases and LED cleared.
// Config writes are taken every cycle; issue them only while the core is idle.
`default_nettype none
module link_reconnect_backoff_core import lrb_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_ready,
  input  wire in_t      in_data,
  output logic          out_valid,
  input  wire           out_ready,
  output out_t          out_data,
  input  wire           cfg_valid,
  output logic          cfg_ready,
  input  wire cfg_idx_t cfg_index,
  input  wire [31:0]    cfg_data
);

  logic   in_vld_r;
  in_t    in_r;
  logic   out_vld_r;
  out_t   out_r;
  cfg_t   cfg_r;
  state_t st_r;
  state_t st_nxt;
  out_t   res;
  logic   advance;

  // Result stage frees when empty or being drained.
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || !out_vld_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  lrb_step u_step (
    .st     (st_r),
    .req    (in_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Control, config and timer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r               <= 1'b0;
      out_vld_r              <= 1'b0;
      cfg_r.initial_delay_ms <= INIT_DELAY_RST;
      cfg_r.max_delay_ms     <= MAX_DELAY_RST;
      cfg_r.fast_blink_ms    <= FAST_BLINK_RST;
      cfg_r.slow_blink_ms    <= SLOW_BLINK_RST;
      st_r                   <= '{backoff_delay: INIT_DELAY_RST, default: '0};
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_INIT_DELAY: cfg_r.initial_delay_ms <= cfg_data;
          REG_MAX_DELAY:  cfg_r.max_delay_ms     <= cfg_data;
          REG_FAST_BLINK: cfg_r.fast_blink_ms    <= cfg_data[15:0];
          REG_SLOW_BLINK: cfg_r.slow_blink_ms    <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

endmodule
`default_nettype wire
